// ----- design/mcot_pkg.sv -----
// ----------------------------------------------------------------------------
// mcot_pkg
// Shared types and constants of the multi-channel one-shot timer core.
// ----------------------------------------------------------------------------
package mcot_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_RESET  = 2'd3
  } func_e;

  typedef struct packed {
    func_e              func;
    logic signed [7:0]  channel_id;
    logic        [31:0] timeout_ticks;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic        expired;
    logic [2:0]  expired_channel;
    logic [15:0] expiry_total;
    logic        last;
  } res_t;

  typedef struct packed {
    func_e       func;
    logic        id_ok;
    logic [6:0]  id;
    logic [31:0] timeout;
  } op_t;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  localparam logic REG_CHANNELS_IN_USE = 1'b0;

endpackage

// ----- design/mcot_front.sv -----
// ----------------------------------------------------------------------------
// mcot_front
// Configuration port, item acceptance and channel id classification.
// ----------------------------------------------------------------------------
module mcot_front #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mcot_pkg::cmd_t                cmd_i,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcot_pkg::ADDR_W-1:0]   paddr,
  input  logic [mcot_pkg::DATA_W-1:0]   pwdata,
  output logic [mcot_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          q_full_i,
  output logic                          push_o,
  output mcot_pkg::op_t                 op_o
);
  import mcot_pkg::*;

  logic [CFG_W-1:0] cfg_q, cfg_d;
  logic [7:0]       lim;
  logic             reg_sel;

  assign reg_sel = (paddr[2] == REG_CHANNELS_IN_USE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? DATA_W'(cfg_q) : '0;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite && reg_sel) begin
      cfg_d = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign lim  = ({4'b0, cfg_q} > 8'(NUM_CHANNELS)) ? 8'(NUM_CHANNELS) : {4'b0, cfg_q};
  assign busy = q_full_i;

  assign push_o        = start && !busy;
  assign op_o.func     = cmd_i.func;
  assign op_o.id       = cmd_i.channel_id[6:0];
  assign op_o.id_ok    = !cmd_i.channel_id[7] && ({1'b0, cmd_i.channel_id[6:0]} < lim);
  assign op_o.timeout  = cmd_i.timeout_ticks;

endmodule

// ----- design/mcot_fifo.sv -----
// ----------------------------------------------------------------------------
// mcot_fifo
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module mcot_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcot_pkg::op_t data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output logic          full_o,
  output mcot_pkg::op_t data_o
);
  import mcot_pkg::*;

  op_t        mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/mcot_back.sv -----
// ----------------------------------------------------------------------------
// mcot_back
// Channel bank: executes commands, counts down on ticks, reports expiries.
// ----------------------------------------------------------------------------
module mcot_back #(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  input  mcot_pkg::op_t  op_i,
  output logic           pop_o,
  output logic           res_valid_o,
  output mcot_pkg::res_t res_o
);
  import mcot_pkg::*;

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic [NUM_CHANNELS-1:0] armed_q, armed_d;
  logic [NUM_CHANNELS-1:0] pend_q, pend_d;
  logic [COUNT_WIDTH-1:0]  rem_q [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  rem_d [NUM_CHANNELS];
  logic [15:0]             cnt_q [NUM_CHANNELS];
  logic [15:0]             cnt_d [NUM_CHANNELS];
  logic [IDX_W-1:0]        ptr_q, ptr_d, idx;
  logic [COUNT_WIDTH-1:0]  tmo;
  logic                    res_valid_q, res_valid_d;
  res_t                    res_q, res_d;

  assign idx = op_i.id[IDX_W-1:0];
  assign tmo = COUNT_WIDTH'(op_i.timeout);

  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    pend_d      = pend_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    pop_o       = 1'b0;
    res_valid_d = 1'b0;
    res_d       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          pop_o = 1'b1;
          case (op_i.func)
            FUNC_TICK: begin
              pend_d = '0;
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (armed_q[i]) begin
                  if (rem_q[i] <= ONE) begin
                    armed_d[i] = 1'b0;
                    rem_d[i]   = '0;
                    cnt_d[i]   = cnt_q[i] + 16'd1;
                    pend_d[i]  = 1'b1;
                  end else begin
                    rem_d[i] = rem_q[i] - ONE;
                  end
                end
              end
              if (|pend_d) begin
                ptr_d   = '0;
                state_d = ST_EMIT;
              end
            end
            FUNC_SET: begin
              res_valid_d  = 1'b1;
              res_d.last   = 1'b1;
              res_d.status = 1'b1;
              if (op_i.id_ok && !armed_q[idx]) begin
                armed_d[idx] = 1'b1;
                rem_d[idx]   = tmo;
                res_d.status = 1'b0;
              end
            end
            FUNC_CANCEL: begin
              res_valid_d  = 1'b1;
              res_d.last   = 1'b1;
              res_d.status = 1'b1;
              if (op_i.id_ok && armed_q[idx]) begin
                armed_d[idx] = 1'b0;
                rem_d[idx]   = '0;
                res_d.status = 1'b0;
              end
            end
            default: begin
              res_valid_d = 1'b1;
              res_d.last  = 1'b1;
              if (op_i.id_ok) begin
                armed_d[idx] = 1'b1;
                rem_d[idx]   = tmo;
              end
            end
          endcase
        end
      end
      ST_EMIT: begin
        ptr_d = IDX_W'(ptr_q + 1'b1);
        if (pend_q[ptr_q]) begin
          pend_d[ptr_q]         = 1'b0;
          res_valid_d           = 1'b1;
          res_d.expired         = 1'b1;
          res_d.expired_channel = 3'(ptr_q);
          res_d.expiry_total    = cnt_q[ptr_q];
          res_d.last            = ~|pend_d;
          if (~|pend_d) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= '0;
      pend_q      <= '0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rem_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      pend_q      <= pend_d;
      ptr_q       <= ptr_d;
      res_valid_q <= res_valid_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- design/multi_channel_oneshot_timer_core.sv -----
// ----------------------------------------------------------------------------
// multi_channel_oneshot_timer_core
// Bank of one-shot timer channels with set, cancel, reset and tick commands.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; up to two items queue
// ahead of the channel bank. A set, cancel or reset gives one result, registered
// once the bank takes the item from the queue, where it waits while the bank is busy.
// A tick updates all channels at once and then, if any channel expired, scans
// the channels one per cycle up to the last expired one; with no expiry it
// holds the bank only for the update. Each expiry comes out as its own result
// in ascending channel order, the final one marked last.
// Results appear on res_o for exactly one cycle with res_valid_o high and must
// be captured then: the receiver cannot stall the block.
// ----------------------------------------------------------------------------
module multi_channel_oneshot_timer_core #(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mcot_pkg::cmd_t                cmd_i,
  output logic                          res_valid_o,
  output mcot_pkg::res_t                res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcot_pkg::ADDR_W-1:0]   paddr,
  input  logic [mcot_pkg::DATA_W-1:0]   pwdata,
  output logic [mcot_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import mcot_pkg::*;

  logic q_full, q_valid, push, pop;
  op_t  op_in, op_out;

  mcot_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .q_full_i (q_full),
    .push_o   (push),
    .op_o     (op_in)
  );

  mcot_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (op_out)
  );

  mcot_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (op_out),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
